### rtl/rdc_pkg.sv
// Shared types, constants and helper functions of the radix digit converter.
`timescale 1ns / 1ps

package rdc_pkg;

    localparam int RADIX_W     = 4;
    localparam int DIGIT_W     = 4;
    localparam int STEP_BITS   = 8;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [RADIX_W-1:0] RADIX_MIN = 4'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 4'd9;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_EMIT
    } rdc_back_state_t;

    typedef struct packed {
        logic full;
        logic empty;
    } rdc_q_status_t;

    // Clamps the programmed radix into the supported range of two to nine.
    function automatic logic [RADIX_W-1:0] rdc_eff_base(input logic [RADIX_W-1:0] radix);
        logic [RADIX_W-1:0] base;
        base = radix;
        if (radix < RADIX_MIN)
        begin
            base = RADIX_MIN;
        end
        else if (radix > RADIX_MAX)
        begin
            base = RADIX_MAX;
        end
        return base;
    endfunction

    // One restoring long-division step: shifts one dividend bit into the
    // remainder and returns the quotient bit on top of the new remainder.
    function automatic logic [DIGIT_W:0] rdc_div_step(
        input logic [DIGIT_W-1:0] rem,
        input logic               bit_in,
        input logic [RADIX_W-1:0] base
    );
        logic [DIGIT_W:0] trial;
        logic [DIGIT_W:0] diff;
        logic [DIGIT_W:0] result;
        trial = {rem, bit_in};
        diff  = trial - {1'b0, base};
        if (trial >= {1'b0, base})
        begin
            result = {1'b1, diff[DIGIT_W-1:0]};
        end
        else
        begin
            result = {1'b0, trial[DIGIT_W-1:0]};
        end
        return result;
    endfunction

endpackage

### rtl/rdc_if.sv
// Handshake channel interfaces of the radix digit converter.
`timescale 1ns / 1ps

interface rdc_value_if #(parameter int VALUE_BITS = 31);
    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink (input valid, input value, output ready);
endinterface

interface rdc_digit_if;
    logic       valid;
    logic       ready;
    logic [3:0] digit;
    logic       last_digit;

    modport source (output valid, output digit, output last_digit, input ready);
    modport sink (input valid, input digit, input last_digit, output ready);
endinterface

interface rdc_cfg_if;
    logic       valid;
    logic       ready;
    logic [3:0] radix;

    modport source (output valid, output radix, input ready);
    modport sink (input valid, input radix, output ready);
endinterface

### rtl/rdc_front.sv
// Front end: holds the radix register, accepts values and queues the nonzero ones.
`timescale 1ns / 1ps

module rdc_front
    import rdc_pkg::*;
#(
    parameter int VALUE_BITS = 31
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    rdc_value_if.sink                     items,
    rdc_cfg_if.sink                       cfg,
    input  rdc_q_status_t                 q_status,
    output logic                          push,
    output logic [VALUE_BITS+RADIX_W-1:0] push_data
);

    logic [RADIX_W-1:0] radix_reg;
    logic [RADIX_W-1:0] radix_next;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        radix_next = radix_reg;
        if (cfg.valid)
        begin
            radix_next = cfg.radix;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= RADIX_MIN;
        end
        else
        begin
            radix_reg <= radix_next;
        end
    end

    // A zero value has no digits at all, so it is accepted and dropped here.
    assign items.ready = !q_status.full;
    assign push        = items.valid && !q_status.full && (items.value != '0);
    assign push_data   = {rdc_eff_base(radix_reg), items.value};

endmodule

### rtl/rdc_queue.sv
// Short queue between the front end and the conversion back end.
`timescale 1ns / 1ps

module rdc_queue
    import rdc_pkg::*;
#(
    parameter int WIDTH = 35
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output rdc_q_status_t    status
);

    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0]  entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;

    assign status.full  = (fill_reg == FILL_W'(QUEUE_DEPTH));
    assign status.empty = (fill_reg == '0);
    assign pop_data     = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### rtl/rdc_back.sv
// Back end: divides repeatedly by the base, stores the digits and replays them in reverse.
`timescale 1ns / 1ps

module rdc_back
    import rdc_pkg::*;
#(
    parameter int VALUE_BITS = 31
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  rdc_q_status_t                 q_status,
    output logic                          pop,
    input  logic [VALUE_BITS+RADIX_W-1:0] pop_data,
    rdc_digit_if.source                   digits
);

    localparam int NCHUNK = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
    localparam int WORK_W = NCHUNK * STEP_BITS;
    localparam int CHK_W  = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam int IDX_W  = $clog2(VALUE_BITS);
    localparam logic [CHK_W-1:0] LAST_CHUNK = CHK_W'(NCHUNK - 1);

    rdc_back_state_t state_reg;
    rdc_back_state_t state_next;

    logic [WORK_W-1:0]    work_reg;
    logic [WORK_W-1:0]    work_next;
    logic [DIGIT_W-1:0]   rem_reg;
    logic [DIGIT_W-1:0]   rem_next;
    logic [RADIX_W-1:0]   base_reg;
    logic [RADIX_W-1:0]   base_next;
    logic [CHK_W-1:0]     chunk_reg;
    logic [CHK_W-1:0]     chunk_next;
    logic [IDX_W-1:0]     wr_idx_reg;
    logic [IDX_W-1:0]     wr_idx_next;
    logic [IDX_W-1:0]     rd_ptr_reg;
    logic [IDX_W-1:0]     rd_ptr_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [DIGIT_W-1:0]   digit_reg;
    logic                 last_reg;
    logic                 last_next;
    logic [DIGIT_W-1:0]   store_mem [VALUE_BITS];
    logic                 store_we;

    logic [STEP_BITS-1:0] qbits;
    logic [DIGIT_W-1:0]   rem_c;
    logic [WORK_W-1:0]    work_shift;
    logic                 last_chunk;
    logic                 quot_zero;
    logic                 emit_load;

    // Eight long-division steps per cycle on the top byte of the work word.
    always_comb
    begin
        logic [DIGIT_W:0] step;
        rem_c = rem_reg;
        qbits = '0;
        for (int i = 0; i < STEP_BITS; i++)
        begin
            step  = rdc_div_step(rem_c, work_reg[WORK_W-1-i], base_reg);
            qbits[STEP_BITS-1-i] = step[DIGIT_W];
            rem_c = step[DIGIT_W-1:0];
        end
    end

    assign work_shift = (work_reg << STEP_BITS) | WORK_W'(qbits);
    assign last_chunk = (chunk_reg == LAST_CHUNK);
    assign quot_zero  = (work_shift == '0);
    assign emit_load  = (state_reg == BK_EMIT) && (!out_valid_reg || digits.ready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_status.empty)
                begin
                    state_next = BK_DIV;
                end
            end
            BK_DIV:
            begin
                if (last_chunk && quot_zero)
                begin
                    state_next = BK_EMIT;
                end
            end
            BK_EMIT:
            begin
                if (emit_load && (rd_ptr_reg == '0))
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pop         = 1'b0;
        store_we    = 1'b0;
        work_next   = work_reg;
        rem_next    = rem_reg;
        base_next   = base_reg;
        chunk_next  = chunk_reg;
        wr_idx_next = wr_idx_reg;
        rd_ptr_next = rd_ptr_reg;
        last_next   = last_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_status.empty)
                begin
                    pop         = 1'b1;
                    work_next   = WORK_W'(pop_data[VALUE_BITS-1:0]);
                    base_next   = pop_data[VALUE_BITS +: RADIX_W];
                    rem_next    = '0;
                    chunk_next  = '0;
                    wr_idx_next = '0;
                end
            end
            BK_DIV:
            begin
                work_next = work_shift;
                if (last_chunk)
                begin
                    store_we    = 1'b1;
                    rem_next    = '0;
                    chunk_next  = '0;
                    wr_idx_next = wr_idx_reg + 1'b1;
                    rd_ptr_next = wr_idx_reg;
                end
                else
                begin
                    rem_next   = rem_c;
                    chunk_next = chunk_reg + 1'b1;
                end
            end
            BK_EMIT:
            begin
                if (emit_load)
                begin
                    last_next   = (rd_ptr_reg == '0);
                    rd_ptr_next = rd_ptr_reg - 1'b1;
                end
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        if (emit_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (digits.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
            chunk_reg     <= '0;
            wr_idx_reg    <= '0;
            rd_ptr_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            chunk_reg     <= chunk_next;
            wr_idx_reg    <= wr_idx_next;
            rd_ptr_reg    <= rd_ptr_next;
        end
    end

    // The digit store is read straight into the output register.
    always_ff @(posedge clk)
    begin
        work_reg  <= work_next;
        rem_reg   <= rem_next;
        base_reg  <= base_next;
        last_reg  <= last_next;
        if (emit_load)
        begin
            digit_reg <= store_mem[rd_ptr_reg];
        end
        if (store_we)
        begin
            store_mem[wr_idx_reg] <= rem_c;
        end
    end

    assign digits.valid      = out_valid_reg;
    assign digits.digit      = digit_reg;
    assign digits.last_digit = last_reg;

endmodule

### rtl/radix_digit_converter_unit.sv
// Top level of the radix digit converter: front end, queue and back end.
`timescale 1ns / 1ps

// The unit turns each non-negative value into its digits in the programmed
// base (two to nine; radix values below two act as two, above nine as nine)
// and sends them most significant first, one transaction per digit, with
// last_digit set on the final one. A value of zero is accepted and yields no
// transactions. The front end samples the radix with each value, so a radix
// write only affects values accepted after it. A two-entry queue lets the
// front end keep accepting values while the back end works. The back end
// handles one value at a time: a shared long-division unit retires eight
// dividend bits per cycle, so each digit takes one pass over the whole
// work word a byte at a time, and the digits are then replayed from the
// digit store at one per cycle while the output is not stalled.
module radix_digit_converter_unit
    import rdc_pkg::*;
#(
    parameter int VALUE_BITS = 31
)
(
    input  logic         clk,
    input  logic         rst_n,
    rdc_value_if.sink    items,
    rdc_digit_if.source  digits,
    rdc_cfg_if.sink      cfg
);

    // Queue entries carry the clamped base on top of the value.
    localparam int ENTRY_W = VALUE_BITS + RADIX_W;

    rdc_q_status_t      q_status;
    logic               q_push;
    logic               q_pop;
    logic [ENTRY_W-1:0] q_push_data;
    logic [ENTRY_W-1:0] q_pop_data;

    rdc_front #(
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .items     (items),
        .cfg       (cfg),
        .q_status  (q_status),
        .push      (q_push),
        .push_data (q_push_data)
    );

    rdc_queue #(
        .WIDTH (ENTRY_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .status    (q_status)
    );

    // The back end owns the division loop, the digit store and the output register.
    rdc_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_status (q_status),
        .pop      (q_pop),
        .pop_data (q_pop_data),
        .digits   (digits)
    );

`ifndef SYNTHESIS
    // The front end must never push into a full queue.
    assert property (@(posedge clk) disable iff (!rst_n) q_status.full |-> !q_push)
        else $error("push into a full queue");

    // The back end must never pop an empty queue.
    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> !q_status.empty)
        else $error("pop from an empty queue");

    // Every digit must lie below the largest supported base.
    assert property (@(posedge clk) disable iff (!rst_n)
        digits.valid |-> (digits.digit < DIGIT_W'(RADIX_MAX)))
        else $error("digit out of range");

    // A pop without a push leaves the queue no longer full in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && !q_push) |=> !q_status.full)
        else $error("queue still full after a pop");
`endif

endmodule
